>>> rtl/mmd_pkg.sv
// package for the multilevel min/max decimator
// register indexes, reset values and widths used by the top level and the testbench
package mmd_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CH_W = 3;
  localparam int unsigned LV_W = 2;
  localparam int unsigned ENTRY_W = 64;

  localparam logic [1:0] REG_WIN_SHORT = 2'd0;
  localparam logic [1:0] REG_WIN_MID = 2'd1;
  localparam logic [1:0] REG_WIN_LONG = 2'd2;

  localparam logic [31:0] WIN_SHORT_RST = 32'd300000;
  localparam logic [31:0] WIN_MID_RST = 32'd3600000;
  localparam logic [31:0] WIN_LONG_RST = 32'd86400000;

  localparam logic [1:0] LIST_SERIES = 2'd0;
  localparam logic [1:0] LIST_PEAK = 2'd1;
  localparam logic [1:0] LIST_TROUGH = 2'd2;

  // spacing divide: x / 80 = ((x >> 4) * ceil(2^34 / 5)) >> 34, exact for 28-bit operands
  localparam logic [33:0] RECIP5 = 34'h0cccccccd;

endpackage

>>> rtl/mmd_ram.sv
// generic single port synchronous ram with registered read
// no dependencies
module mmd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/mmd_div.sv
// restoring divider for the run average, one quotient bit a cycle
// widths are set by its parameters; no dependencies
module mmd_div #(
  parameter int unsigned NUM_W = 40,
  parameter int unsigned DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q;
  logic [DEN_W:0]   r;
  logic [DEN_W-1:0] d;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {r[DEN_W-1:0], q[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= num;
      r <= '0;
      d <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        r <= trial - {1'b0, d};
        q <= {q[NUM_W-2:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot = q;

endmodule

>>> rtl/multilevel_minmax_decimator_top.sv
// top level of the multilevel min/max decimator
// depends on mmd_pkg, mmd_ram and mmd_div
// One sample is handled at a time by a sequencer around one ram that holds, for every
// channel and level, three rings of (value, stamp) entries: the series, the peak list and
// the trough list; ring heads, fill counts and the recent/older extremes sit in flip-flops.
// Per updated level above the first the sequencer walks the lower level's newest run (one
// ram read a cycle) and divides the sum; for each updated level it writes up to three
// entries, expires old entries from each ring, scans the peak and trough rings one entry
// a cycle and reads the next level's newest stamp to decide the last-of-run flag. No
// clearing pass.
module multilevel_minmax_decimator_top #(
  parameter int unsigned CHANNELS = 5,
  parameter int unsigned LEVELS = 3,
  parameter int unsigned RING_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // channel[2:0], sample_value[34:3], sample_time[66:35]
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [135:0] m_tdata,  // channel_out, level, point_value, point_time,
                                 // window_high, window_low
  output logic [1:0]  m_tuser,   // high_logged, low_logged
  output logic        m_tlast
);

  localparam int unsigned SLOTS = CHANNELS * LEVELS;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned FILL_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(SLOTS * 3 * RING_DEPTH);
  localparam int unsigned SUM_W = 32 + FILL_W + 1;
  localparam int unsigned LVI_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CH_W_L = mmd_pkg::CH_W;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_FRONT   = 14'b00000000000010,
    S_CHECK   = 14'b00000000000100,
    S_RUN     = 14'b00000000001000,
    S_DIVGO   = 14'b00000000010000,
    S_DIV     = 14'b00000000100000,
    S_WSER    = 14'b00000001000000,
    S_WPEAK   = 14'b00000010000000,
    S_WTRO    = 14'b00000100000000,
    S_EXP     = 14'b00001000000000,
    S_SCAN    = 14'b00010000000000,
    S_EMIT    = 14'b00100000000000,
    S_WAIT    = 14'b01000000000000,
    S_PEEK    = 14'b10000000000000
  } state_t;

  state_t state;

  logic [31:0] win [3];
  logic [PTR_W-1:0]  head [SLOTS][3];
  logic [FILL_W-1:0] fill [SLOTS][3];
  logic [31:0] rmax [SLOTS];
  logic [31:0] omax [SLOTS];
  logic [31:0] rmin [SLOTS];
  logic [31:0] omin [SLOTS];
  logic [31:0] rstamp [SLOTS];

  logic [CH_W_L-1:0] ch;
  logic signed [31:0] sample;
  logic [31:0] now;
  logic [LVI_W-1:0] lv;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] lslot;
  logic [31:0] sp;
  logic [31:0] curwin;
  logic [FILL_W-1:0] k;
  logic rd_pend;
  logic [1:0] list;
  logic signed [SUM_W-1:0] sum;
  logic [FILL_W-1:0] cnt;
  logic signed [31:0] mn, mx, pv, hi, lo;
  logic stop;
  logic hlog, llog;
  logic neg;

  // ram
  logic ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [63:0] ram_wdata, ram_rdata;

  mmd_ram #(.WIDTH(64), .DEPTH(SLOTS * 3 * RING_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] s,
                                                 input logic [1:0] l,
                                                 input logic [PTR_W-1:0] p);
    addr_of = ADDR_W'((32'(s) * 3 + 32'(l)) * RING_DEPTH + 32'(p));
  endfunction

  function automatic logic [PTR_W-1:0] pos_of(input logic [PTR_W-1:0] h,
                                              input logic [FILL_W-1:0] f,
                                              input logic [FILL_W-1:0] off);
    logic [FILL_W:0] t;
    t = {1'b0, FILL_W'(h)} + {1'b0, f} + {1'b0, off};
    if (t >= (FILL_W + 1)'(RING_DEPTH)) t = t - (FILL_W + 1)'(RING_DEPTH);
    if (t >= (FILL_W + 1)'(RING_DEPTH)) t = t - (FILL_W + 1)'(RING_DEPTH);
    pos_of = PTR_W'(t);
  endfunction

  // divider
  logic div_start, div_done;
  logic [SUM_W-1:0] div_num, div_q;
  mmd_div #(.NUM_W(SUM_W), .DEN_W(FILL_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(cnt),
    .done(div_done), .quot(div_q)
  );
  logic [SUM_W-1:0] abs_sum;
  assign abs_sum = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign div_num = abs_sum + SUM_W'(cnt >> 1);

  // next level lookahead for the last-of-run flag
  logic [SLOT_W-1:0] nslot;
  logic [31:0] nwin;
  logic peek_stop;
  logic emit_go;
  assign nslot = slot + 1'b1;
  assign nwin = (lv == '0) ? win[1] : win[2];
  assign emit_go = (state == S_EMIT) && (!m_tvalid || m_tready);

  // spacing: window / 80 computed after latching window (registered multiply)
  logic [65:0] sp_prod;
  assign sp_prod = 66'((state == S_PEEK) ? nwin[31:4] : curwin[31:4]) *
                   66'(mmd_pkg::RECIP5);

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      mmd_pkg::REG_WIN_SHORT: prdata = win[0];
      mmd_pkg::REG_WIN_MID:   prdata = win[1];
      mmd_pkg::REG_WIN_LONG:  prdata = win[2];
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= mmd_pkg::WIN_SHORT_RST;
      win[1] <= mmd_pkg::WIN_MID_RST;
      win[2] <= mmd_pkg::WIN_LONG_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        mmd_pkg::REG_WIN_SHORT: win[0] <= pwdata;
        mmd_pkg::REG_WIN_MID:   win[1] <= pwdata;
        mmd_pkg::REG_WIN_LONG:  win[2] <= pwdata;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  logic [FILL_W-1:0] f_cur;
  logic [PTR_W-1:0] h_cur;
  assign f_cur = fill[slot][list];
  assign h_cur = head[slot][list];

  logic signed [31:0] rv;
  logic [31:0] rs;
  assign rv = ram_rdata[31:0];
  assign rs = ram_rdata[63:32];

  assign peek_stop = (now - ((fill[nslot][0] != '0) ? rs : 32'd0)) < sp;

  logic hpush, lpush;
  assign hpush = (fill[slot][1] == '0) ||
                 ($signed(omax[slot]) < $signed(rmax[slot]) && $signed(rmax[slot]) >= mx);
  assign lpush = (fill[slot][2] == '0) ||
                 ($signed(omin[slot]) > $signed(rmin[slot]) && $signed(rmin[slot]) <= mn);

  // ram port control
  always_comb begin
    ram_we = 1'b0;
    ram_wdata = '0;
    ram_addr = addr_of(slot, list, h_cur);
    case (state)
      S_FRONT: ram_addr = addr_of(slot, mmd_pkg::LIST_SERIES,
                                  pos_of(head[slot][0], fill[slot][0], FILL_W'(RING_DEPTH - 1)));
      S_RUN: ram_addr = addr_of(lslot, mmd_pkg::LIST_SERIES,
                                pos_of(head[lslot][0], fill[lslot][0],
                                       FILL_W'(RING_DEPTH - 1) - k));
      S_WSER: begin
        ram_we = 1'b1;
        ram_wdata = {now, pv};
        ram_addr = addr_of(slot, mmd_pkg::LIST_SERIES,
                           pos_of(head[slot][0], fill[slot][0], '0));
      end
      S_WPEAK: begin
        ram_we = hpush;
        ram_wdata = (fill[slot][1] == '0) ? {now, mx} : {rstamp[slot], rmax[slot]};
        ram_addr = addr_of(slot, mmd_pkg::LIST_PEAK,
                           pos_of(head[slot][1], fill[slot][1], '0));
      end
      S_WTRO: begin
        ram_we = lpush;
        ram_wdata = (fill[slot][2] == '0) ? {now, mn} : {rstamp[slot], rmin[slot]};
        ram_addr = addr_of(slot, mmd_pkg::LIST_TROUGH,
                           pos_of(head[slot][2], fill[slot][2], '0));
      end
      S_EXP: ram_addr = addr_of(slot, list, h_cur);
      S_SCAN: ram_addr = addr_of(slot, list, pos_of(h_cur, k, '0));
      S_PEEK, S_EMIT: ram_addr = addr_of(nslot, mmd_pkg::LIST_SERIES,
                                         pos_of(head[nslot][0], fill[nslot][0],
                                                FILL_W'(RING_DEPTH - 1)));
      default: ;
    endcase
  end

  logic [PTR_W-1:0] h_inc;
  assign h_inc = (h_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : h_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        for (int l = 0; l < 3; l++) begin
          head[s][l] <= '0;
          fill[s][l] <= '0;
        end
        rmax[s] <= '0; omax[s] <= '0; rmin[s] <= '0; omin[s] <= '0; rstamp[s] <= '0;
      end
      div_start <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      div_start <= (state == S_DIVGO) && (cnt != '0);
      if (emit_go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ch <= s_tdata[2:0];
            sample <= s_tdata[34:3];
            now <= s_tdata[66:35];
            lv <= '0;
            slot <= SLOT_W'(32'(s_tdata[2:0]) * LEVELS);
            curwin <= win[0];
            if (32'(s_tdata[2:0]) < CHANNELS) state <= S_FRONT;
          end
        end
        S_FRONT: begin
          sp <= 32'(sp_prod[65:34]);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (now - ((fill[slot][0] != '0) ? rs : 32'd0) < sp) begin
            state <= S_IDLE;
          end else if (lv == '0) begin
            pv <= sample; mn <= sample; mx <= sample;
            state <= S_WSER;
          end else begin
            k <= '0; sum <= '0; cnt <= '0; stop <= 1'b0; rd_pend <= 1'b0;
            mn <= '0; mx <= '0;
            lslot <= slot - 1'b1;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (rd_pend) begin
            if (cnt == '0 || rv < mn) mn <= rv;
            if (cnt == '0 || rv > mx) mx <= rv;
            sum <= sum + SUM_W'(rv);
            cnt <= cnt + 1'b1;
            if (now - rs > sp) stop <= 1'b1;
          end
          if (stop || (rd_pend && now - rs > sp) || k == fill[lslot][0]
              || (rd_pend && k == fill[lslot][0])) begin
            rd_pend <= 1'b0;
            if (!rd_pend || stop || (now - rs > sp) || k == fill[lslot][0]) begin
              if (!(rd_pend && !(now - rs > sp) && k != fill[lslot][0])) state <= S_DIVGO;
            end
          end else begin
            rd_pend <= 1'b1;
            k <= k + 1'b1;
          end
        end
        S_DIVGO: begin
          neg <= sum[SUM_W-1];
          if (cnt == '0) begin
            pv <= '0;
            state <= S_WSER;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            pv <= neg ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
            state <= S_WSER;
          end
        end
        S_WSER: begin
          list <= mmd_pkg::LIST_SERIES;
          if (fill[slot][0] == FILL_W'(RING_DEPTH)) begin
            head[slot][0] <= (head[slot][0] == PTR_W'(RING_DEPTH - 1)) ? '0
                             : head[slot][0] + 1'b1;
          end else begin
            fill[slot][0] <= fill[slot][0] + 1'b1;
          end
          state <= S_WPEAK;
        end
        S_WPEAK: begin
          hlog <= hpush;
          if (hpush) begin
            if (fill[slot][1] == FILL_W'(RING_DEPTH))
              head[slot][1] <= (head[slot][1] == PTR_W'(RING_DEPTH - 1)) ? '0
                               : head[slot][1] + 1'b1;
            else fill[slot][1] <= fill[slot][1] + 1'b1;
          end
          state <= S_WTRO;
        end
        S_WTRO: begin
          llog <= lpush;
          if (lpush) begin
            if (fill[slot][2] == FILL_W'(RING_DEPTH))
              head[slot][2] <= (head[slot][2] == PTR_W'(RING_DEPTH - 1)) ? '0
                               : head[slot][2] + 1'b1;
            else fill[slot][2] <= fill[slot][2] + 1'b1;
          end
          omin[slot] <= rmin[slot]; rmin[slot] <= mn;
          omax[slot] <= rmax[slot]; rmax[slot] <= mx;
          rstamp[slot] <= now;
          list <= mmd_pkg::LIST_SERIES;
          rd_pend <= 1'b0;
          state <= S_EXP;
        end
        S_EXP: begin
          if (!rd_pend) begin
            if (f_cur == '0) begin
              if (list == mmd_pkg::LIST_TROUGH) begin
                list <= mmd_pkg::LIST_PEAK; k <= '0; hi <= pv; lo <= pv;
                state <= S_SCAN;
              end else list <= list + 1'b1;
            end else rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (now - rs >= curwin) begin
              head[slot][list] <= h_inc;
              fill[slot][list] <= f_cur - 1'b1;
            end else if (list == mmd_pkg::LIST_TROUGH) begin
              list <= mmd_pkg::LIST_PEAK; k <= '0; hi <= pv; lo <= pv;
              state <= S_SCAN;
            end else list <= list + 1'b1;
          end
        end
        S_SCAN: begin
          if (rd_pend) begin
            if (list == mmd_pkg::LIST_PEAK) begin
              if (rv > hi) hi <= rv;
            end else if (rv < lo) lo <= rv;
          end
          if (k == f_cur) begin
            rd_pend <= 1'b0;
            if (list == mmd_pkg::LIST_PEAK) begin
              list <= mmd_pkg::LIST_TROUGH; k <= '0;
            end else state <= (32'(lv) == LEVELS - 1) ? S_EMIT : S_PEEK;
          end else begin
            rd_pend <= 1'b1;
            k <= k + 1'b1;
          end
        end
        S_PEEK: begin
          sp <= 32'(sp_prod[65:34]);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            m_tdata <= {3'b0, lo, hi, now, pv, 2'(lv), ch};
            m_tuser <= {llog, hlog};
            m_tlast <= (32'(lv) == LEVELS - 1) || peek_stop;
            if ((32'(lv) == LEVELS - 1) || peek_stop) state <= S_IDLE;
            else begin
              lv <= lv + 1'b1;
              slot <= slot + 1'b1;
              curwin <= nwin;
              state <= S_FRONT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) s_tready |-> !div_start)
    else $error("divider started while idle");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

>>> tb/multilevel_minmax_decimator_top_tb.sv
// testbench for the multilevel min/max decimator top level
// predicts every level update in the testbench and compares the output stream field by field
// depends on mmd_pkg and multilevel_minmax_decimator_top
module multilevel_minmax_decimator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = 5;
  localparam int NLV = 3;
  localparam int DEPTH = 128;

  typedef struct packed {
    logic [2:0]  ch;
    logic [31:0] value;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    logic [2:0]  ch;
    logic [1:0]  lv;
    logic [31:0] point;
    logic [31:0] stamp;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        hlog;
    logic        llog;
    logic        last;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [135:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  multilevel_minmax_decimator_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] win_ms [3];
  logic signed [31:0] ser_v [NCH][NLV][DEPTH];
  logic [31:0] ser_t [NCH][NLV][DEPTH];
  int ser_h [NCH][NLV], ser_n [NCH][NLV];
  logic signed [31:0] pk_v [NCH][NLV][DEPTH];
  logic [31:0] pk_t [NCH][NLV][DEPTH];
  int pk_h [NCH][NLV], pk_n [NCH][NLV];
  logic signed [31:0] tr_v [NCH][NLV][DEPTH];
  logic [31:0] tr_t [NCH][NLV][DEPTH];
  int tr_h [NCH][NLV], tr_n [NCH][NLV];
  logic signed [31:0] rmax [NCH][NLV], omax [NCH][NLV];
  logic signed [31:0] rmin [NCH][NLV], omin [NCH][NLV];
  logic [31:0] rstamp [NCH][NLV];

  sample_t pending_samples[$];
  update_t expected_updates[$];
  int fails = 0;
  int accepted = 0;
  bit quiet = 1'b0;
  int s_gap = 0, m_gap = 0;

  task automatic ring_add(ref logic signed [31:0] v [DEPTH], ref logic [31:0] t [DEPTH],
                          ref int h, ref int n, input logic signed [31:0] val,
                          input logic [31:0] st);
    int p;
    if (n >= DEPTH) begin
      h = (h + 1) % DEPTH;
      n = DEPTH - 1;
    end
    p = (h + n) % DEPTH;
    v[p] = val;
    t[p] = st;
    n++;
  endtask

  task automatic ring_age(ref logic [31:0] t [DEPTH], ref int h, ref int n,
                          input logic [31:0] now, input logic [31:0] w);
    while (n > 0 && 32'(now - t[h]) >= w) begin
      h = (h + 1) % DEPTH;
      n--;
    end
  endtask

  task automatic predict_updates(input sample_t s);
    int c, n_out;
    logic [31:0] now, w, sp, front;
    logic signed [31:0] pv, mn, mx, hi, lo, v;
    logic signed [63:0] sum, cnt;
    bit hl, ll;
    update_t u;
    c = s.ch;
    now = s.stamp;
    n_out = 0;
    if (c >= NCH) return;
    for (int lv = 0; lv < NLV; lv++) begin
      w = win_ms[lv < 2 ? lv : 2];
      sp = w / 80;
      front = 0;
      if (ser_n[c][lv] > 0) front = ser_t[c][lv][(ser_h[c][lv] + ser_n[c][lv] - 1) % DEPTH];
      if (32'(now - front) < sp) break;
      if (lv > 0) begin
        sum = 0;
        cnt = 0;
        mn = 0;
        mx = 0;
        for (int k = 0; k < ser_n[c][lv-1]; k++) begin
          int p;
          p = (ser_h[c][lv-1] + ser_n[c][lv-1] - 1 - k) % DEPTH;
          v = ser_v[c][lv-1][p];
          if (cnt == 0 || v < mn) mn = v;
          if (cnt == 0 || v > mx) mx = v;
          sum += v;
          cnt++;
          if (32'(now - ser_t[c][lv-1][p]) > sp) break;
        end
        if (cnt == 0) pv = 0;
        else if (sum >= 0) pv = 32'((sum + cnt / 2) / cnt);
        else pv = 32'(-((-sum + cnt / 2) / cnt));
      end else begin
        pv = s.value;
        mn = s.value;
        mx = s.value;
      end
      ring_add(ser_v[c][lv], ser_t[c][lv], ser_h[c][lv], ser_n[c][lv], pv, now);
      hl = 0;
      ll = 0;
      if (pk_n[c][lv] == 0) begin
        ring_add(pk_v[c][lv], pk_t[c][lv], pk_h[c][lv], pk_n[c][lv], mx, now);
        hl = 1;
      end else if (omax[c][lv] < rmax[c][lv] && rmax[c][lv] >= mx) begin
        ring_add(pk_v[c][lv], pk_t[c][lv], pk_h[c][lv], pk_n[c][lv], rmax[c][lv],
                 rstamp[c][lv]);
        hl = 1;
      end
      if (tr_n[c][lv] == 0) begin
        ring_add(tr_v[c][lv], tr_t[c][lv], tr_h[c][lv], tr_n[c][lv], mn, now);
        ll = 1;
      end else if (omin[c][lv] > rmin[c][lv] && rmin[c][lv] <= mn) begin
        ring_add(tr_v[c][lv], tr_t[c][lv], tr_h[c][lv], tr_n[c][lv], rmin[c][lv],
                 rstamp[c][lv]);
        ll = 1;
      end
      omin[c][lv] = rmin[c][lv];
      rmin[c][lv] = mn;
      omax[c][lv] = rmax[c][lv];
      rmax[c][lv] = mx;
      rstamp[c][lv] = now;
      ring_age(ser_t[c][lv], ser_h[c][lv], ser_n[c][lv], now, w);
      ring_age(pk_t[c][lv], pk_h[c][lv], pk_n[c][lv], now, w);
      ring_age(tr_t[c][lv], tr_h[c][lv], tr_n[c][lv], now, w);
      hi = pv;
      for (int k = 0; k < pk_n[c][lv]; k++)
        if (pk_v[c][lv][(pk_h[c][lv] + k) % DEPTH] > hi) hi = pk_v[c][lv][(pk_h[c][lv] + k) % DEPTH];
      lo = pv;
      for (int k = 0; k < tr_n[c][lv]; k++)
        if (tr_v[c][lv][(tr_h[c][lv] + k) % DEPTH] < lo) lo = tr_v[c][lv][(tr_h[c][lv] + k) % DEPTH];
      u = '{ch: 3'(c), lv: 2'(lv), point: pv, stamp: now, hi: hi, lo: lo,
            hlog: hl, llog: ll, last: 1'b0};
      expected_updates.push_back(u);
      n_out++;
    end
    if (n_out > 0) expected_updates[$].last = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        predict_updates(pending_samples.pop_front());
        accepted++;
      end
      if (s_gap > 0) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        s_gap = $urandom_range(1, 10);
        s_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, pending_samples[0].stamp, pending_samples[0].value,
                    pending_samples[0].ch};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    update_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_updates.size() == 0) begin
          $error("unexpected transaction %h", m_tdata);
          fails++;
        end else begin
          e = expected_updates.pop_front();
          if (m_tdata[2:0] !== e.ch) begin
            $error("channel_out exp %0d got %0d", e.ch, m_tdata[2:0]); fails++;
          end
          if (m_tdata[4:3] !== e.lv) begin
            $error("level exp %0d got %0d", e.lv, m_tdata[4:3]); fails++;
          end
          if (m_tdata[36:5] !== e.point) begin
            $error("point_value exp %h got %h", e.point, m_tdata[36:5]); fails++;
          end
          if (m_tdata[68:37] !== e.stamp) begin
            $error("point_time exp %h got %h", e.stamp, m_tdata[68:37]); fails++;
          end
          if (m_tdata[100:69] !== e.hi) begin
            $error("window_high exp %h got %h", e.hi, m_tdata[100:69]); fails++;
          end
          if (m_tdata[132:101] !== e.lo) begin
            $error("window_low exp %h got %h", e.lo, m_tdata[132:101]); fails++;
          end
          if (m_tuser[0] !== e.hlog) begin
            $error("high_logged exp %0d got %0d", e.hlog, m_tuser[0]); fails++;
          end
          if (m_tuser[1] !== e.llog) begin
            $error("low_logged exp %0d got %0d", e.llog, m_tuser[1]); fails++;
          end
          if (m_tlast !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, m_tlast); fails++;
          end
        end
      end
      if (m_gap > 0) begin
        m_gap--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_gap = $urandom_range(1, 10);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    win_ms[idx] = val;
  endtask

  task automatic drain;
    while (pending_samples.size() > 0 || s_tvalid || expected_updates.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic add_sample(input int c, input logic [31:0] v, input logic [31:0] t);
    pending_samples.push_back('{ch: 3'(c), value: v, stamp: t});
  endtask

  task automatic random_phase(input int count, input logic [31:0] step_max);
    logic [31:0] t [NCH];
    int c;
    for (int i = 0; i < NCH; i++) t[i] = $urandom;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(0, 7) == 0 ? $urandom_range(5, 7) : $urandom_range(0, NCH - 1);
      if (c < NCH) t[c] = t[c] + $urandom_range(0, step_max);
      case ($urandom_range(0, 3))
        0: add_sample(c, $urandom, c < NCH ? t[c] : $urandom);
        1: add_sample(c, 32'sh7fffffff - $urandom_range(0, 3), c < NCH ? t[c] : $urandom);
        2: add_sample(c, 32'sh80000000 + $urandom_range(0, 3), c < NCH ? t[c] : $urandom);
        default: add_sample(c, $signed($urandom_range(0, 2000)) - 1000,
                            c < NCH ? t[c] : $urandom);
      endcase
    end
  endtask

  initial begin
    win_ms[0] = mmd_pkg::WIN_SHORT_RST;
    win_ms[1] = mmd_pkg::WIN_MID_RST;
    win_ms[2] = mmd_pkg::WIN_LONG_RST;
    for (int c = 0; c < NCH; c++)
      for (int l = 0; l < NLV; l++) begin
        ser_h[c][l] = 0; ser_n[c][l] = 0; pk_h[c][l] = 0; pk_n[c][l] = 0;
        tr_h[c][l] = 0; tr_n[c][l] = 0; rmax[c][l] = 0; omax[c][l] = 0;
        rmin[c][l] = 0; omin[c][l] = 0; rstamp[c][l] = 0;
      end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // small windows so levels climb quickly
    apb_write(mmd_pkg::REG_WIN_SHORT, 32'd80);
    apb_write(mmd_pkg::REG_WIN_MID, 32'd800);
    apb_write(mmd_pkg::REG_WIN_LONG, 32'd8000);
    add_sample(0, 32'sh7fffffff, 32'd0);
    add_sample(0, 32'sh80000000, 32'd1);
    add_sample(0, 32'd0, 32'd1);
    add_sample(0, 32'sh00010000, 32'd20);
    add_sample(0, 32'shffff0000, 32'd200);
    add_sample(1, 32'd5, 32'hffffffff);
    add_sample(1, 32'd6, 32'd50);
    add_sample(4, 32'sh12345678, 32'd9000);
    add_sample(5, 32'd1, 32'd1);
    add_sample(7, 32'd1, 32'hffffffff);
    add_sample(2, 32'd3, 32'd0);
    for (int i = 0; i < 10; i++) add_sample(3, i[0] ? 32'd100 : -32'sd100, 32'(i * 5));
    drain();
    random_phase(20, 60);
    drain();
    apb_write(mmd_pkg::REG_WIN_SHORT, 32'd4000000000);
    apb_write(mmd_pkg::REG_WIN_MID, 32'd80);
    apb_write(mmd_pkg::REG_WIN_LONG, 32'd80);
    random_phase(30, 32'd100000000);
    drain();
    apb_write(mmd_pkg::REG_WIN_SHORT, 32'd160);
    apb_write(mmd_pkg::REG_WIN_MID, 32'd4000000000);
    apb_write(mmd_pkg::REG_WIN_LONG, 32'd1600);
    quiet = 1'b1;
    random_phase(30, 40);
    drain();
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> files.f
rtl/mmd_pkg.sv
rtl/mmd_ram.sv
rtl/mmd_div.sv
rtl/multilevel_minmax_decimator_top.sv
tb/multilevel_minmax_decimator_top_tb.sv
